@@ rtl/core/i2c_bit_level_master_defines.svh @@
// Assertion macros shared by the I2C bit-level master RTL.
// Each macro expects signals named clock and reset in the calling module.
`ifndef I2C_BIT_LEVEL_MASTER_DEFINES_SVH
`define I2C_BIT_LEVEL_MASTER_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define I2CBL_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define I2CBL_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/i2cbl_pkg.sv @@
// Package for the I2C bit-level master: command codes, sequencer steps
// and the status structure passed from the sequencer to the top level.
package i2cbl_pkg;

   localparam int unsigned CFG_W  = 16;
   localparam int unsigned BYTE_W = 8;

   localparam logic [CFG_W-1:0] DELAY_RESET = 16'd72;

   // Command codes carried in the request.
   localparam logic [2:0] CMD_NONE     = 3'd0;
   localparam logic [2:0] CMD_START    = 3'd1;
   localparam logic [2:0] CMD_STOP     = 3'd2;
   localparam logic [2:0] CMD_WRITE    = 3'd3;
   localparam logic [2:0] CMD_READ     = 3'd4;
   localparam logic [2:0] CMD_WAIT_ACK = 3'd5;

   // Steps of the pin sequences.
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_START_A,
      ST_START_B,
      ST_START_END,
      ST_STOP_A,
      ST_STOP_END,
      ST_WR_BIT,
      ST_WR_HIGH,
      ST_WR_LOW,
      ST_WR_REL,
      ST_WR_END,
      ST_RD_HIGH,
      ST_RD_LOW,
      ST_RD_ACK,
      ST_RD_ACKH,
      ST_RD_ACKL,
      ST_RD_END,
      ST_WA_REL,
      ST_WA_HIGH,
      ST_WA_SAMPLE,
      ST_WA_END
   } step_type;

   // Pin levels and status after one request has been processed.
   typedef struct packed {
      logic              nack;
      logic [BYTE_W-1:0] rx_byte;
      logic              done;
      logic              busy;
      logic              sda;
      logic              scl;
   } seq_status_type;

endpackage

@@ rtl/core/i2c_bit_level_master.sv @@
// I2C bit-level master: a request's result is registered at the edge that accepts it
// and is offered from the next cycle on. Throughput is one request per cycle while the
// result side does not stall, set by the single pass through the sequencer step logic.
// Reset (synchronous, active high) idles the sequencer, sets SCL and SDA released
// high, clears flags and the received byte, and loads a delay setting of 72.
// Depends on i2cbl_pkg, i2cbl_sequencer and the defines header.
`include "i2c_bit_level_master_defines.svh"

module i2c_bit_level_master
   import i2cbl_pkg::*;
#(
   parameter int unsigned DELAY_COUNTER_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   // Request: [2:0] cmd, [10:3] tx_byte, [11] send_ack, [12] sda_in, [15:13] zero
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [15:0]      req_tdata,
   // Result: [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res,
   // [11:4] rx_byte, [12] nack_seen, [15:13] zero
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [15:0]      rsp_tdata,
   // Delay register write: cycles_per_delay
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CFG_W-1:0] csr_data
);

   logic [CFG_W-1:0] csr_delay_ff;
   logic             rsp_valid_ff;
   seq_status_type   rsp_data_ff;
   seq_status_type   next_status;
   logic             req_accept;

   // A request is taken whenever the result register is empty or drains now.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   i2cbl_sequencer #(
      .DELAY_COUNTER_BITS (DELAY_COUNTER_BITS)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .step_en          (req_accept),
      .cmd              (req_tdata[2:0]),
      .tx_byte          (req_tdata[10:3]),
      .send_ack         (req_tdata[11]),
      .sda_in           (req_tdata[12]),
      .cycles_per_delay (csr_delay_ff),
      .next_status      (next_status)
   );

   // Delay register.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_delay_ff <= DELAY_RESET;
      end else if (csr_valid && csr_ready) begin
         csr_delay_ff <= csr_data;
      end
   end

   // Result register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result register payload.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= next_status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_data_ff};

   // Every accepted request leaves a result waiting.
   `I2CBL_CHECK_NEXT(a_rsp_after_req, req_accept, rsp_valid_ff, "result missing after request")
   // The delay register holds the last written value.
   `I2CBL_CHECK_NEXT(a_csr_write, csr_valid, csr_delay_ff == $past(csr_data), "delay write lost")
   // An empty result register never stalls the request side.
   `I2CBL_CHECK(a_ready_empty, rsp_valid_ff || req_tready, "stall with empty result register")

endmodule

@@ rtl/core/i2cbl_sequencer.sv @@
// Pin sequencer of the I2C bit-level master: step state machine, delay
// down-counter and shift register. Depends on i2cbl_pkg and the defines header.
`include "i2c_bit_level_master_defines.svh"

module i2cbl_sequencer
   import i2cbl_pkg::*;
#(
   parameter int unsigned DELAY_COUNTER_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  logic [2:0]           cmd,
   input  logic [BYTE_W-1:0]    tx_byte,
   input  logic                 send_ack,
   input  logic                 sda_in,
   input  logic [CFG_W-1:0]     cycles_per_delay,
   output seq_status_type       next_status
);

   localparam int unsigned CW = DELAY_COUNTER_BITS;
   localparam logic [32:0] DELAY_MAX = (33'd1 << CW) - 33'd1;

   step_type          step_ff, step_in;
   logic [CW-1:0]     dcnt_ff, dcnt_in;
   logic [3:0]        bit_ff, bit_in;
   logic [BYTE_W-1:0] shift_ff, shift_in;
   logic              scl_ff, scl_in;
   logic              sda_ff, sda_in_lvl;
   logic              ack_ff, ack_in;
   logic              nack_ff, nack_in;
   logic [BYTE_W-1:0] rx_ff, rx_in;

   logic              cmd_ok;
   logic              starting;
   logic              run_enter;
   logic              count_down;
   logic              do_enter;
   step_type          phase;
   logic [BYTE_W-1:0] sh_base;
   logic [BYTE_W-1:0] shift_left;
   logic [3:0]        bi_base;
   logic [3:0]        bit_inc;
   logic              ack_base;
   logic [CW-1:0]     delay_load;
   logic [32:0]       cfg_wide;
   logic              done_in;

   // Delay reload value: zero counts as one, large values saturate.
   assign cfg_wide = {17'd0, cycles_per_delay};
   always_comb begin
      if (cycles_per_delay == '0) begin
         delay_load = CW'(1);
      end else if (cfg_wide > DELAY_MAX) begin
         delay_load = DELAY_MAX[CW-1:0];
      end else begin
         delay_load = cfg_wide[CW-1:0];
      end
   end

   // Decide whether this request starts a command, waits, or enters a step.
   assign cmd_ok     = (cmd >= CMD_START) && (cmd <= CMD_WAIT_ACK);
   assign starting   = step_en && (step_ff == ST_IDLE) && cmd_ok;
   assign run_enter  = step_en && (step_ff != ST_IDLE) && (dcnt_ff <= CW'(1));
   assign count_down = step_en && (step_ff != ST_IDLE) && (dcnt_ff > CW'(1));
   assign do_enter   = starting || run_enter;

   // Step to enter: the first step of a new command, or the pending one.
   always_comb begin
      phase = step_ff;
      if (starting) begin
         unique case (cmd)
            CMD_START: phase = ST_START_A;
            CMD_STOP:  phase = ST_STOP_A;
            CMD_WRITE: phase = ST_WR_BIT;
            CMD_READ:  phase = ST_RD_HIGH;
            default:   phase = ST_WA_REL;
         endcase
      end
   end

   // Working values seen by the entered step.
   assign sh_base    = starting ? ((cmd == CMD_WRITE) ? tx_byte : '0) : shift_ff;
   assign bi_base    = starting ? 4'd0 : bit_ff;
   assign ack_base   = starting ? send_ack : ack_ff;
   assign bit_inc    = bi_base + 4'd1;
   assign shift_left = {sh_base[BYTE_W-2:0], 1'b0};

   // Next step and delay counter.
   always_comb begin
      step_in = step_ff;
      if (do_enter) begin
         unique case (phase)
            ST_START_A:   step_in = ST_START_B;
            ST_START_B:   step_in = ST_START_END;
            ST_STOP_A:    step_in = ST_STOP_END;
            ST_WR_BIT:    step_in = ST_WR_HIGH;
            ST_WR_HIGH:   step_in = ST_WR_LOW;
            ST_WR_LOW:    step_in = bit_inc[3] ? ST_WR_REL : ST_WR_BIT;
            ST_WR_REL:    step_in = ST_WR_END;
            ST_RD_HIGH:   step_in = ST_RD_LOW;
            ST_RD_LOW:    step_in = bit_inc[3] ? ST_RD_ACK : ST_RD_HIGH;
            ST_RD_ACK:    step_in = ST_RD_ACKH;
            ST_RD_ACKH:   step_in = ST_RD_ACKL;
            ST_RD_ACKL:   step_in = ST_RD_END;
            ST_WA_REL:    step_in = ST_WA_HIGH;
            ST_WA_HIGH:   step_in = ST_WA_SAMPLE;
            ST_WA_SAMPLE: step_in = ST_WA_END;
            default:      step_in = ST_IDLE;
         endcase
      end
   end

   always_comb begin
      dcnt_in = dcnt_ff;
      if (do_enter) begin
         dcnt_in = (step_in == ST_IDLE) ? '0 : delay_load;
      end else if (count_down) begin
         dcnt_in = dcnt_ff - CW'(1);
      end
   end

   // Pin levels, shift register and flags set by the entered step.
   always_comb begin
      scl_in     = scl_ff;
      sda_in_lvl = sda_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      ack_in     = ack_ff;
      nack_in    = nack_ff;
      rx_in      = rx_ff;
      if (starting) begin
         bit_in   = 4'd0;
         shift_in = sh_base;
         ack_in   = send_ack;
      end
      if (do_enter) begin
         unique case (phase)
            ST_START_A: begin
               sda_in_lvl = 1'b1;
               scl_in     = 1'b1;
            end
            ST_START_B:  sda_in_lvl = 1'b0;
            ST_STOP_A: begin
               sda_in_lvl = 1'b0;
               scl_in     = 1'b1;
            end
            ST_STOP_END: sda_in_lvl = 1'b1;
            ST_WR_BIT: begin
               scl_in     = 1'b0;
               sda_in_lvl = sh_base[BYTE_W-1];
            end
            ST_WR_HIGH:  scl_in = 1'b1;
            ST_WR_LOW: begin
               scl_in   = 1'b0;
               shift_in = shift_left;
               bit_in   = bit_inc;
            end
            ST_WR_REL:   sda_in_lvl = 1'b1;
            ST_RD_HIGH: begin
               shift_in = shift_left;
               scl_in   = 1'b1;
            end
            ST_RD_LOW: begin
               shift_in = {sh_base[BYTE_W-1:1], sh_base[0] | sda_in};
               scl_in   = 1'b0;
               bit_in   = bit_inc;
            end
            ST_RD_ACK:   sda_in_lvl = !ack_base;
            ST_RD_ACKH:  scl_in = 1'b1;
            ST_RD_ACKL:  scl_in = 1'b0;
            ST_RD_END: begin
               sda_in_lvl = 1'b1;
               rx_in      = sh_base;
            end
            ST_WA_REL:   sda_in_lvl = 1'b1;
            ST_WA_HIGH:  scl_in = 1'b1;
            ST_WA_SAMPLE: begin
               nack_in = sda_in;
               scl_in  = 1'b0;
            end
            default: begin
               // Final steps only return to idle.
            end
         endcase
      end
   end

   assign done_in = do_enter && (step_in == ST_IDLE);

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= ST_IDLE;
         dcnt_ff  <= '0;
         bit_ff   <= 4'd0;
         shift_ff <= '0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         ack_ff   <= 1'b0;
         nack_ff  <= 1'b0;
         rx_ff    <= '0;
      end else begin
         step_ff  <= step_in;
         dcnt_ff  <= dcnt_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in_lvl;
         ack_ff   <= ack_in;
         nack_ff  <= nack_in;
         rx_ff    <= rx_in;
      end
   end

   // Status after this request, captured by the result register.
   assign next_status.scl     = scl_in;
   assign next_status.sda     = sda_in_lvl;
   assign next_status.busy    = (step_in != ST_IDLE);
   assign next_status.done    = done_in;
   assign next_status.rx_byte = rx_in;
   assign next_status.nack    = nack_in;

   // The delay counter runs exactly while a sequence is active.
   `I2CBL_CHECK(a_dcnt_busy, (step_ff == ST_IDLE) == (dcnt_ff == '0), "delay count out of step")
   // The bit counter never passes eight.
   `I2CBL_CHECK(a_bit_range, !bit_ff[3] || (bit_ff[2:0] == 3'd0), "bit index beyond eight")
   // A completing sequence never reports busy at the same time.
   `I2CBL_CHECK(a_done_idle, !done_in || (step_in == ST_IDLE), "done while still busy")

endmodule

@@ tb/i2c_bit_level_master_checker.sv @@
// Checker for the I2C bit-level master: watches the request, result and delay
// register channels, predicts each result request by request and compares it.
// Depends on i2cbl_pkg for command codes, step names and the status layout.
module i2c_bit_level_master_checker
   import i2cbl_pkg::*;
#(
   parameter int unsigned DELAY_COUNTER_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [15:0]      req_tdata,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [15:0]      rsp_tdata,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [CFG_W-1:0] csr_data,
   output int               mismatch_count,
   output int               outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   // Mirror of the sequencer state and the delay register.
   logic [CFG_W-1:0]  delay_setting;
   step_type          step;
   int unsigned       delay_left;
   logic [3:0]        bit_count;
   logic [BYTE_W-1:0] shifter;
   logic [BYTE_W-1:0] rx_hold;
   logic              scl_lvl;
   logic              sda_lvl;
   logic              ack_bit;
   logic              nack_bit;
   logic              done_bit;

   // Pin status expected for each accepted request, oldest first.
   seq_status_type    pin_status_q[$];

   function automatic void clear_sequencer();
      delay_setting = DELAY_RESET;
      step = ST_IDLE;
      delay_left = 0;
      bit_count = '0;
      shifter = '0;
      rx_hold = '0;
      scl_lvl = 1'b1;
      sda_lvl = 1'b1;
      ack_bit = 1'b0;
      nack_bit = 1'b0;
      done_bit = 1'b0;
   endfunction

   // A zero setting counts as one unit; larger ones clamp to the counter range.
   function automatic void load_delay(step_type next_step);
      longint unsigned units;
      longint unsigned ceiling;
      units = 64'(delay_setting);
      ceiling = (64'd1 << DELAY_COUNTER_BITS) - 1;
      if (units == 0) begin
         units = 1;
      end
      if (units > ceiling) begin
         units = ceiling;
      end
      delay_left = int'(units);
      step = next_step;
   endfunction

   function automatic void complete();
      step = ST_IDLE;
      delay_left = 0;
      done_bit = 1'b1;
   endfunction

   // Pin changes made on entering a step.
   function automatic void enter_step(step_type s, logic sda_in);
      case (s)
         ST_START_A: begin
            sda_lvl = 1'b1;
            scl_lvl = 1'b1;
            load_delay(ST_START_B);
         end
         ST_START_B: begin
            sda_lvl = 1'b0;
            load_delay(ST_START_END);
         end
         ST_STOP_A: begin
            sda_lvl = 1'b0;
            scl_lvl = 1'b1;
            load_delay(ST_STOP_END);
         end
         ST_STOP_END: begin
            sda_lvl = 1'b1;
            complete();
         end
         ST_WR_BIT: begin
            scl_lvl = 1'b0;
            sda_lvl = shifter[BYTE_W-1];
            load_delay(ST_WR_HIGH);
         end
         ST_WR_HIGH: begin
            scl_lvl = 1'b1;
            load_delay(ST_WR_LOW);
         end
         ST_WR_LOW: begin
            scl_lvl = 1'b0;
            shifter = shifter << 1;
            bit_count = bit_count + 4'd1;
            load_delay(bit_count >= 4'd8 ? ST_WR_REL : ST_WR_BIT);
         end
         ST_WR_REL: begin
            sda_lvl = 1'b1;
            load_delay(ST_WR_END);
         end
         ST_RD_HIGH: begin
            shifter = shifter << 1;
            scl_lvl = 1'b1;
            load_delay(ST_RD_LOW);
         end
         ST_RD_LOW: begin
            shifter[0] = shifter[0] | sda_in;
            scl_lvl = 1'b0;
            bit_count = bit_count + 4'd1;
            load_delay(bit_count >= 4'd8 ? ST_RD_ACK : ST_RD_HIGH);
         end
         ST_RD_ACK: begin
            sda_lvl = ~ack_bit;
            load_delay(ST_RD_ACKH);
         end
         ST_RD_ACKH: begin
            scl_lvl = 1'b1;
            load_delay(ST_RD_ACKL);
         end
         ST_RD_ACKL: begin
            scl_lvl = 1'b0;
            load_delay(ST_RD_END);
         end
         ST_RD_END: begin
            sda_lvl = 1'b1;
            rx_hold = shifter;
            complete();
         end
         ST_WA_REL: begin
            sda_lvl = 1'b1;
            load_delay(ST_WA_HIGH);
         end
         ST_WA_HIGH: begin
            scl_lvl = 1'b1;
            load_delay(ST_WA_SAMPLE);
         end
         ST_WA_SAMPLE: begin
            nack_bit = sda_in;
            scl_lvl = 1'b0;
            load_delay(ST_WA_END);
         end
         default: begin
            complete();
         end
      endcase
   endfunction

   // One step of the sequencer for an accepted request; commands are taken only when idle.
   function automatic seq_status_type sequence_tick(logic [2:0] cmd, logic [BYTE_W-1:0] tx,
                                                    logic ack, logic sda_in);
      seq_status_type status;
      done_bit = 1'b0;
      if (step == ST_IDLE) begin
         if (cmd >= CMD_START && cmd <= CMD_WAIT_ACK) begin
            bit_count = '0;
            shifter = (cmd == CMD_WRITE) ? tx : '0;
            ack_bit = ack;
            case (cmd)
               CMD_START: enter_step(ST_START_A, sda_in);
               CMD_STOP:  enter_step(ST_STOP_A, sda_in);
               CMD_WRITE: enter_step(ST_WR_BIT, sda_in);
               CMD_READ:  enter_step(ST_RD_HIGH, sda_in);
               default:   enter_step(ST_WA_REL, sda_in);
            endcase
         end
      end else if (delay_left > 1) begin
         delay_left = delay_left - 1;
      end else begin
         enter_step(step, sda_in);
      end
      status.scl = scl_lvl;
      status.sda = sda_lvl;
      status.busy = (step != ST_IDLE);
      status.done = done_bit;
      status.rx_byte = rx_hold;
      status.nack = nack_bit;
      return status;
   endfunction

   task automatic check_field(input string label, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      end
   endtask

   // Registers apply first, then the result is checked, then the request predicted.
   always @(posedge clock) begin
      seq_status_type actual;
      seq_status_type want;
      if (reset) begin
         clear_sequencer();
         pin_status_q.delete();
         mismatch_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            delay_setting = csr_data;
         end
         if (rsp_tvalid && rsp_tready) begin
            actual = seq_status_type'(rsp_tdata[12:0]);
            if (pin_status_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: result with no request pending, expected none, actual %h",
                        $time, rsp_tdata);
            end else begin
               want = pin_status_q.pop_front();
               check_field("scl_out", 32'(want.scl), 32'(actual.scl));
               check_field("sda_out", 32'(want.sda), 32'(actual.sda));
               check_field("busy", 32'(want.busy), 32'(actual.busy));
               check_field("done", 32'(want.done), 32'(actual.done));
               check_field("rx_byte", 32'(want.rx_byte), 32'(actual.rx_byte));
               check_field("nack_seen", 32'(want.nack), 32'(actual.nack));
            end
         end
         if (req_tvalid && req_tready) begin
            pin_status_q.push_back(sequence_tick(req_tdata[2:0], req_tdata[10:3],
                                                 req_tdata[11], req_tdata[12]));
         end
      end
      outstanding = pin_status_q.size();
   end

endmodule

@@ tb/i2c_bit_level_master_test.sv @@
// Top of the I2C bit-level master testbench: clock, reset, request and result
// traffic, delay register writes and the verdict. Needs i2cbl_pkg, the block
// and i2c_bit_level_master_checker, which does all prediction and comparison.
module i2c_bit_level_master_test
   import i2cbl_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // Codes the block must ignore.
   localparam logic [2:0] CMD_UNDEF_6 = 3'd6;
   localparam logic [2:0] CMD_UNDEF_7 = 3'd7;
   // Line mode for filler requests: a fixed level or a fresh random one.
   localparam int SDA_LOW    = 0;
   localparam int SDA_HIGH   = 1;
   localparam int SDA_RANDOM = 2;

   logic             clock;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [15:0]      req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [15:0]      rsp_tdata;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CFG_W-1:0] csr_data = '0;

   int               mismatch_count;
   int               outstanding;
   int               done_count = 0;
   logic             last_busy = 1'b0;
   bit               quiet = 1'b0;
   bit               long_hold = 1'b0;

   i2c_bit_level_master u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   i2c_bit_level_master_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Completed sequences and the latest busy flag steer the stimulus.
   always @(posedge clock) begin
      seq_status_type status;
      if (!reset && rsp_tvalid && rsp_tready) begin
         status = seq_status_type'(rsp_tdata[12:0]);
         last_busy = status.busy;
         if (status.done) begin
            done_count++;
         end
      end
   end

   // Mostly short idle spans with an occasional long one.
   function automatic int idle_span();
      return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
   endfunction

   function automatic logic line_level(int mode);
      return (mode == SDA_RANDOM) ? logic'($urandom_range(0, 1)) : logic'(mode);
   endfunction

   // Mostly real commands, with none and the undefined codes mixed in.
   function automatic logic [2:0] random_code();
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0:       return CMD_NONE;
         1:       return CMD_UNDEF_6;
         2:       return CMD_UNDEF_7;
         default: return 3'($urandom_range(CMD_START, CMD_WAIT_ACK));
      endcase
   endfunction

   // Result side: random stalls, one long hold-off on request, none when quiet.
   initial begin
      int hold;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            hold = 64;
         end else if (quiet || $urandom_range(0, 3) != 0) begin
            hold = 0;
         end else begin
            hold = idle_span();
         end
         if (hold == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            repeat (hold - 1) @(negedge clock);
            long_hold = 1'b0;
         end
      end
   end

   // Offers one request and returns at the falling edge after it is taken.
   task automatic send_request(input logic [2:0] cmd, input logic [BYTE_W-1:0] tx,
                               input logic ack, input logic sda);
      req_tdata <= {3'b000, sda, ack, tx, cmd};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic write_delay(input logic [CFG_W-1:0] value);
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Sends fillers until the sequencer is idle and every result is back.
   task automatic settle();
      while (outstanding != 0 || last_busy) begin
         if (last_busy) begin
            send_request(CMD_NONE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
         end else begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
      end
      req_tvalid <= 1'b0;
   endtask

   // One command from idle, then fillers of no command until it completes.
   task automatic run_command(input logic [2:0] cmd, input logic [BYTE_W-1:0] tx,
                              input logic ack, input int sda_mode);
      int target;
      target = done_count + 1;
      send_request(cmd, tx, ack, line_level(sda_mode));
      if (cmd >= CMD_START && cmd <= CMD_WAIT_ACK) begin
         while (done_count < target) begin
            send_request(CMD_NONE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         line_level(sda_mode));
         end
      end
   endtask

   // Random traffic until the given number of sequences has completed.
   task automatic run_random(input int commands, input bit with_hold);
      int target;
      int gap;
      bit held;
      target = done_count + commands;
      held = 1'b0;
      while (done_count < target) begin
         send_request(random_code(), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
         if (with_hold && !held && done_count >= target - commands / 2) begin
            long_hold = 1'b1;
            held = 1'b1;
         end
         gap = (!quiet && $urandom_range(0, 3) == 0) ? idle_span() : 0;
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      settle();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: one stop at the reset delay.
      run_command(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM);
      settle();

      // Directed: shortest delay, a full frame, reads of all ones and all zeros,
      // both ack choices, a missing acknowledge and the ignored codes.
      write_delay(16'd1);
      run_command(CMD_START, 8'h00, 1'b0, SDA_RANDOM);
      run_command(CMD_WRITE, 8'hA5, 1'b0, SDA_RANDOM);
      run_command(CMD_WAIT_ACK, 8'hFF, 1'b1, SDA_HIGH);
      run_command(CMD_READ, 8'hFF, 1'b1, SDA_HIGH);
      run_command(CMD_READ, 8'h00, 1'b0, SDA_LOW);
      run_command(CMD_WAIT_ACK, 8'h00, 1'b0, SDA_LOW);
      run_command(CMD_NONE, 8'hFF, 1'b1, SDA_HIGH);
      run_command(CMD_UNDEF_6, 8'hFF, 1'b1, SDA_HIGH);
      run_command(CMD_UNDEF_7, 8'hFF, 1'b1, SDA_HIGH);
      run_command(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM);
      settle();

      // Directed: a zero setting behaves as one unit.
      write_delay(16'd0);
      run_command(CMD_START, 8'h00, 1'b0, SDA_RANDOM);
      run_command(CMD_WAIT_ACK, 8'h00, 1'b0, SDA_RANDOM);
      run_command(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM);
      settle();

      // Random traffic over several short delays; one phase stalls the results.
      write_delay(16'd1);
      run_random(5, 1'b0);
      write_delay(16'd2);
      run_random(5, 1'b1);
      write_delay(16'd0);
      run_random(4, 1'b0);
      quiet = 1'b1;
      write_delay(CFG_W'($urandom_range(1, 3)));
      run_random(4, 1'b0);
      quiet = 1'b0;

      repeat (4) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("[i2c_bit_level_master] OK");
      end else begin
         $display("[i2c_bit_level_master] ERROR");
      end
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #1000000;
      $display("[i2c_bit_level_master] ERROR");
      $finish;
   end

endmodule
